[rtl/core/lmbc_pkg.sv]
// Shared types and constants for the LED blink/burst controller.
// Depends on nothing; every module of the controller imports it.
`timescale 1ns / 1ps
`default_nettype none

package lmbc_pkg;

   localparam int OP_W = 3;
   localparam int IDX_W = 3;
   localparam int MS_W = 13;
   localparam int TICK_W = 8;
   localparam int BITS_W = 8;
   localparam int LED_COUNT_DEF = 8;
   localparam logic [TICK_W-1:0] TICK_RESET = 8'd8;

   // Operation codes. The same encoding serves as an LED's mode, where
   // OP_TICK stands for "no mode yet" and OP_TOGGLE never occurs.
   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_OFF    = 3'd1,
      OP_ON     = 3'd2,
      OP_BLINK  = 3'd3,
      OP_TOGGLE = 3'd4,
      OP_BURST  = 3'd5
   } op_type;

   // Broadcast from the pipeline to every LED cell for the item in work.
   typedef struct packed {
      logic               step;
      logic [OP_W-1:0]    operation;
      logic [IDX_W-1:0]   led_index;
      logic [MS_W-1:0]    millis_value;
   } led_ctl_type;

endpackage

`default_nettype wire

[rtl/core/led_mode_blink_burst_controller.sv]
// LED blink/burst controller top level: input register, LED cells, result register.
// Depends on lmbc_pkg and lmbc_led_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock cycle while req_ready is high and returns one result
// item per item: the item waits in an input register, is applied to all LED
// cells in parallel when it moves on, and the light bitmap is held in a result
// register until taken. req_ready drops only when both registers hold an item
// that cannot move on. A tick item applies every LED's pending command and then
// moves its blink or burst countdown by csr_tick_ms; a command item only latches
// that LED's pending command. csr_tick_ms may be written at any cycle that the
// block is idle, and resets to 8.
module led_mode_blink_burst_controller #(
   parameter int LED_COUNT = lmbc_pkg::LED_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lmbc_pkg::OP_W-1:0]     req_operation,
   input  wire logic [lmbc_pkg::IDX_W-1:0]    req_led_index,
   input  wire logic [lmbc_pkg::MS_W-1:0]     req_millis_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lmbc_pkg::BITS_W-1:0]        rsp_light_bits,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lmbc_pkg::TICK_W-1:0]   csr_tick_ms
);
   import lmbc_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [OP_W-1:0]       in_op_ff;
   logic [IDX_W-1:0]      in_idx_ff;
   logic [MS_W-1:0]       in_ms_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BITS_W-1:0]     rsp_bits_ff, rsp_bits_in;
   logic [TICK_W-1:0]     tick_ms_ff;
   logic                  move;
   logic                  req_take;
   led_ctl_type           ctl;
   logic [LED_COUNT-1:0]  lit_next;

   assign move = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign req_take = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_ready);
   assign csr_ready = 1'b1;

   assign ctl.step = move;
   assign ctl.operation = in_op_ff;
   assign ctl.led_index = in_idx_ff;
   assign ctl.millis_value = in_ms_ff;

   for (genvar g = 0; g < LED_COUNT; g++) begin : g_led
      lmbc_led_cell #(
         .LED_ID(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .tick_ms  (tick_ms_ff),
         .lit_next (lit_next[g])
      );
   end

   // Only the first eight LEDs show in the bitmap.
   for (genvar b = 0; b < BITS_W; b++) begin : g_bits
      if (b < LED_COUNT) begin : g_used
         assign rsp_bits_in[b] = lit_next[b];
      end else begin : g_unused
         assign rsp_bits_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ms_ff <= TICK_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) tick_ms_ff <= csr_tick_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff <= req_operation;
         in_idx_ff <= req_led_index;
         in_ms_ff <= req_millis_value;
      end
      if (move) rsp_bits_ff <= rsp_bits_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_light_bits = rsp_bits_ff;

   // A command item only latches a pending command, so the lights stay as
   // they were shown for the previous item.
   a_cmd_keeps_lights: assert property (@(posedge clock) disable iff (reset)
      (move && in_op_ff != OP_TICK) |=> (rsp_light_bits == $past(rsp_bits_in) &&
         ($past(rsp_bits_in) == $past(rsp_light_bits) || !$past(rsp_valid_ff)
          || $past(rsp_ready))))
      else $error("command item changed the light bitmap");

   // An item held in the input register is never dropped while stalled.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |=> (in_valid_ff && $stable(in_op_ff)
         && $stable(in_idx_ff) && $stable(in_ms_ff)))
      else $error("stalled item left the input register");

   // A configuration write lands in the tick register.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (tick_ms_ff == $past(csr_tick_ms)))
      else $error("tick register did not take the written value");

   // Each moved item produces exactly one result in the next cycle.
   a_move_gives_result: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("item moved without a result");

endmodule

`default_nettype wire

[rtl/core/lmbc_led_cell.sv]
// State and update logic of one LED: pending command, mode, countdown, light.
// Depends on lmbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmbc_led_cell #(
   parameter int LED_ID = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lmbc_pkg::led_ctl_type         ctl,
   input  wire logic [lmbc_pkg::TICK_W-1:0]   tick_ms,
   output logic                               lit_next
);
   import lmbc_pkg::*;

   localparam logic [5:0] ID = 6'(LED_ID);

   op_type                pend_code_ff, pend_code_in;
   logic [MS_W-1:0]       pend_ms_ff, pend_ms_in;
   op_type                mode_ff, mode_in;
   logic [MS_W-1:0]       period_ff, period_in;
   logic [MS_W-1:0]       left_ff, left_in;
   logic                  lit_ff, lit_in;

   op_type                cmd_op;
   logic                  cmd_we;
   logic                  is_tick;
   logic [MS_W-1:0]       tick_ext;

   assign cmd_op = op_type'(ctl.operation);
   assign is_tick = ctl.step && (cmd_op == OP_TICK);
   assign cmd_we = ctl.step && (cmd_op inside {OP_OFF, OP_ON, OP_BLINK, OP_TOGGLE, OP_BURST})
                   && ({3'b000, ctl.led_index} == ID);
   assign tick_ext = {{(MS_W-TICK_W){1'b0}}, tick_ms};

   always_comb begin
      pend_code_in = pend_code_ff;
      pend_ms_in = pend_ms_ff;
      mode_in = mode_ff;
      period_in = period_ff;
      left_in = left_ff;
      lit_in = lit_ff;
      if (cmd_we) begin
         pend_code_in = cmd_op;
         pend_ms_in = (cmd_op == OP_BLINK || cmd_op == OP_BURST) ? ctl.millis_value
                                                                  : '0;
      end else if (is_tick) begin
         // First apply the pending command.
         if (pend_code_ff != OP_TICK) begin
            pend_code_in = OP_TICK;
            pend_ms_in = '0;
            if (pend_code_ff == mode_ff) begin
               if (pend_code_ff == OP_BLINK) begin
                  period_in = pend_ms_ff;
                  if (pend_ms_ff < left_ff) left_in = pend_ms_ff;
               end else if (pend_code_ff == OP_BURST) begin
                  left_in = pend_ms_ff;
               end
            end else begin
               case (pend_code_ff)
                  OP_OFF: begin
                     lit_in = 1'b0;
                     mode_in = OP_OFF;
                  end
                  OP_ON: begin
                     lit_in = 1'b1;
                     mode_in = OP_ON;
                  end
                  OP_BLINK: begin
                     period_in = pend_ms_ff;
                     left_in = pend_ms_ff;
                     mode_in = OP_BLINK;
                  end
                  OP_BURST: begin
                     left_in = pend_ms_ff;
                     mode_in = OP_BURST;
                  end
                  OP_TOGGLE: begin
                     // The mode settles on the steady state that was reached.
                     lit_in = ~lit_ff;
                     mode_in = lit_ff ? OP_OFF : OP_ON;
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
         end
         // Then advance the countdown.
         if (mode_in == OP_BLINK) begin
            if (left_in >= tick_ext) begin
               left_in = left_in - tick_ext;
            end else begin
               left_in = period_in;
               lit_in = ~lit_in;
            end
         end else if (mode_in == OP_BURST) begin
            if (left_in >= tick_ext) begin
               left_in = left_in - tick_ext;
               lit_in = 1'b1;
            end else begin
               lit_in = 1'b0;
               mode_in = OP_OFF;
            end
         end
      end
   end

   assign lit_next = lit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_code_ff <= OP_TICK;
         pend_ms_ff <= '0;
         mode_ff <= OP_TICK;
         period_ff <= '0;
         left_ff <= '0;
         lit_ff <= 1'b0;
      end else begin
         pend_code_ff <= pend_code_in;
         pend_ms_ff <= pend_ms_in;
         mode_ff <= mode_in;
         period_ff <= period_in;
         left_ff <= left_in;
         lit_ff <= lit_in;
      end
   end

endmodule

`default_nettype wire
